// ===== rtl/core/rfp_pkg.sv =====
// shared types, constants and codes for the reader response frame parser
`default_nettype none
package rfp_pkg;

	localparam int BUFFER_BYTES_DEF = 128;

	localparam logic [7:0] HDR_TFI = 8'hD5;
	localparam logic [7:0] HDR_CMD = 8'h41;
	localparam logic [7:0] ERR_MASK = 8'h3F;
	localparam logic [7:0] MAX_LEN_RESET = 8'hFF;
	localparam logic [7:0] HDR_OVERHEAD = 8'd3;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_DEV_ERROR = 2'd2;
	localparam logic [1:0] KIND_NO_HEADER = 2'd3;

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_STATUS,
		PH_PAYLOAD,
		PH_ERROR
	} rfp_phase_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_read;
	} rfp_in_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [5:0] error_code;
		logic [7:0] payload_length;
		logic       last;
	} rfp_out_t;

	// results produced by one accepted input word, first in order first
	typedef struct packed {
		logic [1:0] cnt;
		rfp_out_t   first;
		rfp_out_t   second;
	} rfp_push_t;

endpackage
`default_nettype wire

// ===== rtl/core/rfp_parser.sv =====
// header search, status check and payload counting for one read
`default_nettype none
module rfp_parser #(
	parameter int BufferBytes = rfp_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_fire,
	input  wire rfp_pkg::rfp_in_t in_word,
	input  wire logic            cfg_we,
	input  wire logic [7:0]      cfg_data,
	output rfp_pkg::rfp_push_t   push
);
	import rfp_pkg::*;

	localparam int PosW = $clog2(BufferBytes + 1);

	logic [7:0]     hist0_q, hist1_q, hist2_q;
	logic [PosW-1:0] pos_q;
	rfp_phase_t     phase_q, phase_nxt;
	logic [7:0]     flen_q, flen_nxt;
	logic [7:0]     remain_q, remain_nxt;
	logic [7:0]     emitted_q, emitted_nxt;
	logic [7:0]     max_len_q;

	logic       in_range;
	logic       emit_data;
	logic [7:0] len_raw;
	logic [7:0] len_clip;
	logic [5:0] status_err;
	rfp_out_t   data_res;
	rfp_out_t   end_res;

	assign in_range   = pos_q < PosW'(BufferBytes);
	assign status_err = in_word.rx_byte[5:0] & ERR_MASK[5:0];
	assign len_raw    = (flen_q > HDR_OVERHEAD) ? flen_q - HDR_OVERHEAD : 8'd0;
	assign len_clip   = (len_raw > max_len_q) ? max_len_q : len_raw;
	assign emit_data  = in_range && (phase_q == PH_PAYLOAD) && (remain_q != 8'd0);

	// next phase
	always_comb begin
		phase_nxt = phase_q;
		if (in_range) begin
			case (phase_q)
				PH_SEARCH: begin
					if (hist0_q == HDR_TFI && in_word.rx_byte == HDR_CMD)
						phase_nxt = PH_STATUS;
				end
				PH_STATUS: begin
					phase_nxt = (status_err != 6'd0) ? PH_ERROR : PH_PAYLOAD;
				end
				PH_PAYLOAD: phase_nxt = PH_PAYLOAD;
				PH_ERROR:   phase_nxt = PH_ERROR;
				default:    phase_nxt = PH_SEARCH;
			endcase
		end
	end

	// datapath and results
	always_comb begin
		flen_nxt    = flen_q;
		remain_nxt  = remain_q;
		emitted_nxt = emitted_q;
		if (in_range) begin
			case (phase_q)
				PH_SEARCH: begin
					if (hist0_q == HDR_TFI && in_word.rx_byte == HDR_CMD)
						flen_nxt = hist2_q;
				end
				PH_STATUS: begin
					if (status_err != 6'd0)
						flen_nxt = {2'b00, status_err};
					else
						remain_nxt = len_clip;
				end
				PH_PAYLOAD: begin
					if (emit_data) begin
						remain_nxt  = remain_q - 8'd1;
						emitted_nxt = emitted_q + 8'd1;
					end
				end
				default: ;
			endcase
		end

		data_res = '0;
		data_res.kind = KIND_DATA;
		data_res.data_byte = in_word.rx_byte;

		end_res = '0;
		end_res.last = 1'b1;
		case (phase_nxt)
			PH_PAYLOAD: begin
				end_res.kind = KIND_DONE;
				end_res.payload_length = emitted_nxt;
			end
			PH_ERROR: begin
				end_res.kind = KIND_DEV_ERROR;
				end_res.error_code = flen_nxt[5:0];
			end
			default: end_res.kind = KIND_NO_HEADER;
		endcase

		push = '0;
		if (in_fire) begin
			if (emit_data) begin
				push.first = data_res;
				push.second = end_res;
				push.cnt = in_word.end_of_read ? 2'd2 : 2'd1;
			end else if (in_word.end_of_read) begin
				push.first = end_res;
				push.cnt = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist0_q   <= '0;
			hist1_q   <= '0;
			hist2_q   <= '0;
			pos_q     <= '0;
			phase_q   <= PH_SEARCH;
			flen_q    <= '0;
			remain_q  <= '0;
			emitted_q <= '0;
		end else if (in_fire) begin
			if (in_word.end_of_read) begin
				hist0_q   <= '0;
				hist1_q   <= '0;
				hist2_q   <= '0;
				pos_q     <= '0;
				phase_q   <= PH_SEARCH;
				flen_q    <= '0;
				remain_q  <= '0;
				emitted_q <= '0;
			end else begin
				if (in_range) begin
					hist2_q <= hist1_q;
					hist1_q <= hist0_q;
					hist0_q <= in_word.rx_byte;
					pos_q   <= pos_q + PosW'(1);
				end
				phase_q   <= phase_nxt;
				flen_q    <= flen_nxt;
				remain_q  <= remain_nxt;
				emitted_q <= emitted_nxt;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_eor_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_word.end_of_read |-> push.cnt != 2'd0 &&
			((push.cnt == 2'd1 && push.first.last) ||
			 (push.cnt == 2'd2 && push.second.last && !push.first.last)))
		else $error("read end without a closing outcome");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PosW'(BufferBytes))
		else $error("position ran past the buffer");
	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !in_word.end_of_read && emit_data |=> emitted_q == $past(emitted_q) + 8'd1)
		else $error("emitted count out of step with data words");
	a_no_data_outside_payload: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_PAYLOAD |-> !emit_data)
		else $error("data word outside the payload phase");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/rfp_out_queue.sv =====
// four-entry result queue, takes up to two words per cycle and gives one while out_stall is low
`default_nettype none
module rfp_out_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rfp_pkg::rfp_push_t push,
	output logic                   full,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output rfp_pkg::rfp_out_t      out_data
);
	import rfp_pkg::*;

	localparam int Depth = 4;
	localparam int PtrW  = $clog2(Depth);
	localparam int CntW  = $clog2(Depth + 1);

	rfp_out_t        mem_q [Depth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] cnt_q;
	logic            pop;

	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && !out_stall;
	// room for two words is needed before a new input word is taken
	assign full      = cnt_q > CntW'(Depth - 2);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			mem_q[wr_q] <= push.first;
		if (push.cnt == 2'd2)
			mem_q[wr_q + PtrW'(1)] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PtrW'(push.cnt);
			if (pop)
				rd_q <= rd_q + PtrW'(1);
			cnt_q <= cnt_q + CntW'(push.cnt) - CntW'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd0 |-> !full)
		else $error("queue written while full");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(Depth))
		else $error("queue count above depth");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd0 && !pop |=> cnt_q == $past(cnt_q))
		else $error("queue count moved with no push or pop");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/reader_response_frame_parser_core.sv =====
// top level of the reader response frame parser
//
//  channel  dir  handshake            word
//  in       in   in_valid / in_stall  rfp_in_t: rx_byte, end_of_read
//  out      out  out_valid / out_stall rfp_out_t: kind, data_byte, error_code,
//                                     payload_length, last
//  cfg      in   cfg_valid / cfg_ready max_response_length, 8 bits
//
// one input word per cycle while in_stall is low; its results enter a
// four-entry queue at the same edge and leave it in order as out_stall
// allows. the final byte of a read can give two words (data then outcome),
// so the queue sets the stall when fewer than two places are free. reset
// clears all read state, sets the capacity to 255. cfg_ready is always high.
`default_nettype none
module reader_response_frame_parser_core #(
	parameter int BufferBytes = rfp_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire rfp_pkg::rfp_in_t  in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output rfp_pkg::rfp_out_t      out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [7:0]       cfg_data
);
	import rfp_pkg::*;

	rfp_push_t push;
	logic      q_full;
	logic      in_fire;

	assign in_stall  = q_full;
	assign in_fire   = in_valid && !q_full;
	assign cfg_ready = 1'b1;

	rfp_parser #(
		.BufferBytes(BufferBytes)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.in_word (in_data),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.push    (push)
	);

	rfp_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (q_full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the reader response frame parser core
module tb_top;
	import rfp_pkg::*;

	localparam int BUF_BYTES = BUFFER_BYTES_DEF;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	rfp_in_t in_data;
	logic out_valid;
	logic out_stall;
	rfp_out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [7:0] cfg_data;

	// parser state as predicted
	logic [7:0] capacity;
	logic [7:0] hist [3];
	int read_pos;
	rfp_phase_t read_phase;
	logic [7:0] held_len;
	logic [7:0] remain;
	logic [7:0] emitted;

	rfp_out_t expected_words [$];
	int fail_count = 0;
	int words_in = 0;
	int reads_closed = 0;
	int words_out = 0;
	int kinds_seen [4] = '{0, 0, 0, 0};
	int cycle_count = 0;
	bit tx_idle_on = 1'b0;
	bit rx_idle_on = 1'b0;
	bit hold_request = 1'b0;

	reader_response_frame_parser_core #(
		.BufferBytes(BUF_BYTES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cycle_count,
				expected_words.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [7:0] rand_byte(input int lo, input int hi);
		int unsigned r;
		r = $urandom_range(hi, lo);
		return r[7:0];
	endfunction

	function automatic rfp_out_t result_word(input logic [1:0] kind, input logic [7:0] data,
		input logic [5:0] code, input logic [7:0] len, input logic last);
		rfp_out_t w;
		w.kind = kind;
		w.data_byte = data;
		w.error_code = code;
		w.payload_length = len;
		w.last = last;
		return w;
	endfunction

	function automatic void clear_read();
		hist = '{8'h00, 8'h00, 8'h00};
		read_pos = 0;
		read_phase = PH_SEARCH;
		held_len = 8'h00;
		remain = 8'h00;
		emitted = 8'h00;
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s", msg);
		end
	endfunction

	// works out the words that one accepted input word causes
	function automatic void predict_word(input logic [7:0] b, input logic eor);
		logic [7:0] plen;
		if (read_pos < BUF_BYTES) begin
			case (read_phase)
				PH_SEARCH: begin
					if (hist[0] == HDR_TFI && b == HDR_CMD) begin
						held_len = hist[2];
						read_phase = PH_STATUS;
					end
				end
				PH_STATUS: begin
					if ((b & ERR_MASK) != 8'h00) begin
						held_len = b & ERR_MASK;
						read_phase = PH_ERROR;
					end else begin
						plen = (held_len > HDR_OVERHEAD) ? held_len - HDR_OVERHEAD : 8'h00;
						if (plen > capacity) begin
							plen = capacity;
						end
						remain = plen;
						read_phase = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					if (remain != 8'h00) begin
						expected_words.push_back(result_word(KIND_DATA, b, 6'd0, 8'd0, 1'b0));
						remain--;
						emitted++;
					end
				end
				default: begin
				end
			endcase
			hist[2] = hist[1];
			hist[1] = hist[0];
			hist[0] = b;
			read_pos++;
		end
		if (eor) begin
			if (read_phase == PH_PAYLOAD) begin
				expected_words.push_back(result_word(KIND_DONE, 8'd0, 6'd0, emitted, 1'b1));
			end else if (read_phase == PH_ERROR) begin
				expected_words.push_back(result_word(KIND_DEV_ERROR, 8'd0, held_len[5:0], 8'd0,
					1'b1));
			end else begin
				expected_words.push_back(result_word(KIND_NO_HEADER, 8'd0, 6'd0, 8'd0, 1'b1));
			end
			reads_closed++;
			clear_read();
		end
	endfunction

	// output checker, values seen as they were at the edge
	always @(posedge clk) begin : check_results
		rfp_out_t want;
		if (arst_n === 1'b1 && out_valid && !out_stall) begin
			words_out++;
			kinds_seen[out_data.kind]++;
			if (expected_words.size() == 0) begin
				note_failure($sformatf("unexpected word at cycle %0d: kind %0d data %02h",
					cycle_count, out_data.kind, out_data.data_byte));
			end else begin
				want = expected_words.pop_front();
				if (out_data.kind !== want.kind || out_data.data_byte !== want.data_byte ||
					out_data.error_code !== want.error_code ||
					out_data.payload_length !== want.payload_length ||
					out_data.last !== want.last) begin
					note_failure($sformatf(
						"mismatch at cycle %0d: exp kind %0d data %02h code %02h len %0d last %0b",
						cycle_count, want.kind, want.data_byte, want.error_code,
						want.payload_length, want.last));
					if (fail_count <= 10) begin
						$display("  got kind %0d data %02h code %02h len %0d last %0b",
							out_data.kind, out_data.data_byte, out_data.error_code,
							out_data.payload_length, out_data.last);
					end
				end
			end
		end
	end

	// receiver side: random stall bursts, or one long hold on request
	initial begin : receiver_stall
		int burst;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_request = 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 14);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_word(input logic [7:0] b, input logic eor);
		rfp_in_t w;
		int gap;
		w.rx_byte = b;
		w.end_of_read = eor;
		if (tx_idle_on && $urandom_range(0, 6) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_word(b, eor);
		words_in++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		capacity = v;
	endtask

	task automatic send_frame(input logic [7:0] frame [$]);
		foreach (frame[i]) begin
			send_word(frame[i], i == frame.size() - 1);
		end
	endtask

	// mostly well-formed frames, some cut short, some plain noise
	task automatic send_random_read();
		logic [7:0] frame [$];
		logic [7:0] status;
		int n_pay;
		int flen;
		int cut;
		int mode;
		mode = $urandom_range(0, 99);
		repeat ($urandom_range(0, 2)) frame.push_back(rand_byte(0, 255));
		n_pay = $urandom_range(0, 12);
		flen = n_pay + 3;
		if ($urandom_range(0, 7) == 0) begin
			flen = $urandom_range(0, 255);
		end
		// length checksum sits between the length and the header pair
		frame.push_back(flen[7:0]);
		frame.push_back(8'(256 - flen));
		frame.push_back(HDR_TFI);
		frame.push_back(HDR_CMD);
		if ($urandom_range(0, 4) == 0) begin
			frame.push_back(rand_byte(1, 255));
		end else begin
			status = rand_byte(0, 3);
			frame.push_back({status[1:0], 6'd0});
		end
		repeat (n_pay) frame.push_back(rand_byte(0, 255));
		repeat ($urandom_range(0, 2)) frame.push_back(rand_byte(0, 255));
		if (mode >= 85) begin
			frame.delete();
			repeat ($urandom_range(1, 8)) frame.push_back(rand_byte(0, 255));
		end else if (mode >= 70) begin
			cut = $urandom_range(1, frame.size());
			while (frame.size() > cut) void'(frame.pop_back());
		end
		send_frame(frame);
	endtask

	task automatic test_basic_payload();
		// last payload byte and outcome both come from the final word
		send_frame('{8'h05, 8'hFB, HDR_TFI, HDR_CMD, 8'h00, 8'hFF, 8'h00});
	endtask

	task automatic test_device_error();
		// trailing byte after the error status is ignored
		send_frame('{8'h12, 8'hEE, HDR_TFI, HDR_CMD, 8'h3F, 8'h77});
	endtask

	task automatic test_header_cases();
		// pair at the very start with no length byte and no status
		send_frame('{HDR_TFI, HDR_CMD});
		send_frame('{8'h5A});
	endtask

	task automatic test_trailing_bytes();
		// status with only the upper bits set is not an error
		send_frame('{8'h04, 8'hFC, HDR_TFI, HDR_CMD, 8'hC0, 8'hAA, 8'h55});
	endtask

	task automatic test_capacity_mid_read();
		drain_results();
		write_capacity(MAX_LEN_RESET);
		send_word(8'h09, 1'b0);
		send_word(8'hF7, 1'b0);
		send_word(HDR_TFI, 1'b0);
		send_word(HDR_CMD, 1'b0);
		drain_results();
		// new capacity must apply to the status byte still to come
		write_capacity(8'd2);
		send_frame('{8'h00, 8'h11, 8'h22, 8'h33});
		drain_results();
	endtask

	task automatic test_backpressure();
		logic [7:0] frame [$];
		drain_results();
		write_capacity(MAX_LEN_RESET);
		hold_request = 1'b1;
		frame = '{8'd33, 8'hDF, HDR_TFI, HDR_CMD, 8'h00};
		repeat (30) frame.push_back(rand_byte(0, 255));
		send_frame(frame);
		drain_results();
	endtask

	task automatic test_overlong_reads();
		logic [7:0] frame [$];
		drain_results();
		write_capacity(MAX_LEN_RESET);
		// payload runs past the buffer end and is cut there
		frame = '{8'hFF, 8'h01, HDR_TFI, HDR_CMD, 8'h00};
		repeat (130) frame.push_back(rand_byte(0, 255));
		send_frame(frame);
		// header lands at the buffer end, its status falls outside
		frame.delete();
		repeat (BUF_BYTES - 2) frame.push_back(rand_byte(0, 8'hD4));
		frame.push_back(HDR_TFI);
		frame.push_back(HDR_CMD);
		frame.push_back(8'h00);
		frame.push_back(rand_byte(0, 255));
		send_frame(frame);
		drain_results();
	endtask

	task automatic test_random_reads(input logic [7:0] cap, input int n_items);
		int start;
		drain_results();
		write_capacity(cap);
		start = words_in;
		while (words_in - start < n_items) send_random_read();
		drain_results();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= 8'h00;
		capacity = MAX_LEN_RESET;
		clear_read();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		test_basic_payload();
		test_device_error();
		test_header_cases();
		test_trailing_bytes();
		test_capacity_mid_read();
		test_backpressure();

		test_random_reads(MAX_LEN_RESET, 260);
		test_random_reads(8'd0, 200);
		test_random_reads(8'd1, 150);
		test_random_reads(rand_byte(2, 15), 250);
		test_overlong_reads();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		test_random_reads(rand_byte(0, 255), 250);
		drain_results();

		$display("sent %0d input words in %0d reads, capacities 255, 0, 1 and random,",
			words_in, reads_closed);
		$display("checked %0d words: %0d data, %0d done, %0d device error, %0d no header",
			words_out, kinds_seen[KIND_DATA], kinds_seen[KIND_DONE],
			kinds_seen[KIND_DEV_ERROR], kinds_seen[KIND_NO_HEADER]);
		if (fail_count == 0 && expected_words.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d failures, %0d words never arrived", fail_count, expected_words.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
